// ===== rtl/core/mse_pkg.sv =====
// Shared types, control-word layout and microprogram of the merge sort engine.
// Used by mse_seq, mse_datapath and merge_sort_engine; depends on nothing else.
`timescale 1ns / 1ps

package mse_pkg;

  // Datapath operation selected by the current control word.
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_INIT,
    OP_PASS,
    OP_PAIR,
    OP_RD_A,
    OP_RD_B,
    OP_LAT_B,
    OP_MERGE,
    OP_FETCH,
    OP_OUT_INIT,
    OP_OUT_RD,
    OP_OUT_LAT
  } op_t;

  // Branch condition tested by the sequencer.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_LAST_ACC,
    C_WIDTH_GE_N,
    C_BASE_GE_N,
    C_RUNS_DONE,
    C_OUT_FREE,
    C_OUT_END
  } cond_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Step addresses of the microprogram.
  localparam pc_t S_LOAD     = 4'd0;
  localparam pc_t S_INIT     = 4'd1;
  localparam pc_t S_PASS     = 4'd2;
  localparam pc_t S_PAIR     = 4'd3;
  localparam pc_t S_RDA      = 4'd4;
  localparam pc_t S_RDB      = 4'd5;
  localparam pc_t S_LATB     = 4'd6;
  localparam pc_t S_MERGE    = 4'd7;
  localparam pc_t S_FETCH    = 4'd8;
  localparam pc_t S_OUT_INIT = 4'd9;
  localparam pc_t S_OUT_RD   = 4'd10;
  localparam pc_t S_OUT_LAT  = 4'd11;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt_t;   // next step when the condition holds
    pc_t   tgt_f;   // next step otherwise
  } uword_t;

  // Flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic last_acc;
    logic width_ge_n;
    logic base_ge_n;
    logic runs_done;
    logic out_free;
    logic out_end;
  } status_t;

  // Control store. Passes are bottom-up: the run width doubles each pass and
  // the two stores swap roles as source and destination.
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      S_LOAD:     w = '{op: OP_LOAD,     cond: C_LAST_ACC,   tgt_t: S_INIT,     tgt_f: S_LOAD};
      S_INIT:     w = '{op: OP_INIT,     cond: C_ALWAYS,     tgt_t: S_PASS,     tgt_f: S_PASS};
      S_PASS:     w = '{op: OP_PASS,     cond: C_WIDTH_GE_N, tgt_t: S_OUT_INIT, tgt_f: S_PAIR};
      S_PAIR:     w = '{op: OP_PAIR,     cond: C_BASE_GE_N,  tgt_t: S_PASS,     tgt_f: S_RDA};
      S_RDA:      w = '{op: OP_RD_A,     cond: C_ALWAYS,     tgt_t: S_RDB,      tgt_f: S_RDB};
      S_RDB:      w = '{op: OP_RD_B,     cond: C_ALWAYS,     tgt_t: S_LATB,     tgt_f: S_LATB};
      S_LATB:     w = '{op: OP_LAT_B,    cond: C_ALWAYS,     tgt_t: S_MERGE,    tgt_f: S_MERGE};
      S_MERGE:    w = '{op: OP_MERGE,    cond: C_RUNS_DONE,  tgt_t: S_PAIR,     tgt_f: S_FETCH};
      S_FETCH:    w = '{op: OP_FETCH,    cond: C_ALWAYS,     tgt_t: S_MERGE,    tgt_f: S_MERGE};
      S_OUT_INIT: w = '{op: OP_OUT_INIT, cond: C_ALWAYS,     tgt_t: S_OUT_RD,   tgt_f: S_OUT_RD};
      S_OUT_RD:   w = '{op: OP_OUT_RD,   cond: C_OUT_FREE,   tgt_t: S_OUT_LAT,  tgt_f: S_OUT_RD};
      S_OUT_LAT:  w = '{op: OP_OUT_LAT,  cond: C_OUT_END,    tgt_t: S_LOAD,     tgt_f: S_OUT_RD};
      default:    w = '{op: OP_LOAD,     cond: C_ALWAYS,     tgt_t: S_LOAD,     tgt_f: S_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/mse_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== rtl/core/mse_seq.sv =====
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  mse_pkg::status_t  status,
  output mse_pkg::uword_t   ctrl
);

  mse_pkg::pc_t pc_r;
  mse_pkg::pc_t pc_nxt;
  logic         hit;

  assign ctrl = mse_pkg::ucode_rom(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      mse_pkg::C_ALWAYS:     hit = 1'b1;
      mse_pkg::C_LAST_ACC:   hit = status.last_acc;
      mse_pkg::C_WIDTH_GE_N: hit = status.width_ge_n;
      mse_pkg::C_BASE_GE_N:  hit = status.base_ge_n;
      mse_pkg::C_RUNS_DONE:  hit = status.runs_done;
      mse_pkg::C_OUT_FREE:   hit = status.out_free;
      mse_pkg::C_OUT_END:    hit = status.out_end;
      default:               hit = 1'b1;
    endcase
    pc_nxt = hit ? ctrl.tgt_t : ctrl.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mse_pkg::S_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/core/mse_datapath.sv =====
// Datapath of the merge sort engine: value and scratch stores, run pointers,
// merge compare, item count and the output register.
// Depends on mse_pkg and mse_ram.
`timescale 1ns / 1ps

module mse_datapath #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mse_pkg::op_t      op,
  output mse_pkg::status_t  status,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic              out_tlast
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int WW = CW + 1;
  localparam int SW = CW + 2;

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [WW-1:0]         width_r, width_nxt;
  logic [CW-1:0]         base_r, base_nxt;
  logic [CW-1:0]         a_r, a_nxt, a_end_r, a_end_nxt;
  logic [CW-1:0]         b_r, b_nxt, b_end_r, b_end_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [VALUE_BITS-1:0] head_a_r, head_a_nxt, head_b_r, head_b_nxt;
  logic                  src_r, src_nxt;
  logic                  sel_a_r, sel_a_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [15:0]           out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                      in_acc;
  logic [VALUE_BITS+15:0]    in_ext;
  logic [VALUE_BITS-1:0]     in_value;
  logic [SW-1:0]             mid_sum, hi_sum;
  logic [CW-1:0]             mid_cl, hi_cl;
  logic                      a_valid, b_valid, take_a;
  logic [CW-1:0]             a_inc, b_inc;
  logic                      store_free, load_we, merge_we;
  logic [AW-1:0]             waddr, raddr;
  logic [CW-1:0]             raddr_full;
  logic [VALUE_BITS-1:0]     wdata, merge_data, rd0, rd1, rdata;
  logic [VALUE_BITS+15:0]    rd_ext;

  assign in_tready = (op == mse_pkg::OP_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign in_ext    = {{VALUE_BITS{1'b0}}, in_tdata};
  assign in_value  = in_ext[VALUE_BITS-1:0];

  // Bounds of the next pair of runs, clipped to the set size.
  assign mid_sum = SW'(base_r) + SW'(width_r);
  assign hi_sum  = mid_sum + SW'(width_r);
  assign mid_cl  = (mid_sum > SW'(cnt_r)) ? cnt_r : mid_sum[CW-1:0];
  assign hi_cl   = (hi_sum > SW'(cnt_r)) ? cnt_r : hi_sum[CW-1:0];

  assign a_valid = a_r < a_end_r;
  assign b_valid = b_r < b_end_r;
  // On equal heads the right-hand run goes first.
  assign take_a  = a_valid && (!b_valid || (head_a_r < head_b_r));
  assign a_inc   = a_r + CW'(1);
  assign b_inc   = b_r + CW'(1);

  assign store_free = cnt_r < CW'(MAX_ITEMS);
  assign load_we    = in_acc && store_free;
  assign merge_we   = (op == mse_pkg::OP_MERGE) && (a_valid || b_valid);
  assign merge_data = take_a ? head_a_r : head_b_r;
  assign wdata      = (op == mse_pkg::OP_LOAD) ? in_value : merge_data;
  assign waddr      = (op == mse_pkg::OP_LOAD) ? cnt_r[AW-1:0] : k_r[AW-1:0];

  always_comb begin
    unique case (op)
      mse_pkg::OP_RD_B:   raddr_full = b_r;
      mse_pkg::OP_MERGE:  raddr_full = take_a ? a_inc : b_inc;
      mse_pkg::OP_OUT_RD: raddr_full = idx_r;
      default:            raddr_full = a_r;
    endcase
  end
  // A read one past the end of a run may wrap; its data is never used.
  assign raddr = raddr_full[AW-1:0];

  // Store 0 takes new sets and is the first pass's source.
  mse_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_value_store (
    .clk     (clk),
    .we      (load_we || (merge_we && src_r)),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rd0)
  );

  mse_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_scratch_store (
    .clk     (clk),
    .we      (merge_we && !src_r),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rd1)
  );

  assign rdata  = src_r ? rd1 : rd0;
  assign rd_ext = {16'b0, rdata};

  assign status.last_acc   = in_acc && in_tlast;
  assign status.width_ge_n = width_r >= WW'(cnt_r);
  assign status.base_ge_n  = base_r >= cnt_r;
  assign status.runs_done  = !a_valid && !b_valid;
  assign status.out_free   = !out_valid_r || out_tready;
  assign status.out_end    = idx_r == (cnt_r - CW'(1));

  always_comb begin
    cnt_nxt       = cnt_r;
    width_nxt     = width_r;
    base_nxt      = base_r;
    a_nxt         = a_r;
    a_end_nxt     = a_end_r;
    b_nxt         = b_r;
    b_end_nxt     = b_end_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    head_a_nxt    = head_a_r;
    head_b_nxt    = head_b_r;
    src_nxt       = src_r;
    sel_a_nxt     = sel_a_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (op)
      mse_pkg::OP_LOAD: begin
        if (load_we) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      mse_pkg::OP_INIT: begin
        width_nxt = WW'(1);
        src_nxt   = 1'b0;
      end
      mse_pkg::OP_PASS: begin
        base_nxt = '0;
        k_nxt    = '0;
      end
      mse_pkg::OP_PAIR: begin
        if (base_r >= cnt_r) begin
          width_nxt = width_r << 1;
          src_nxt   = !src_r;
        end else begin
          a_nxt     = base_r;
          a_end_nxt = mid_cl;
          b_nxt     = mid_cl;
          b_end_nxt = hi_cl;
        end
      end
      mse_pkg::OP_RD_A: begin
      end
      mse_pkg::OP_RD_B: begin
        head_a_nxt = rdata;
      end
      mse_pkg::OP_LAT_B: begin
        head_b_nxt = rdata;
      end
      mse_pkg::OP_MERGE: begin
        if (!a_valid && !b_valid) begin
          base_nxt = b_end_r;
        end else begin
          k_nxt     = k_r + CW'(1);
          sel_a_nxt = take_a;
          if (take_a) begin
            a_nxt = a_inc;
          end else begin
            b_nxt = b_inc;
          end
        end
      end
      mse_pkg::OP_FETCH: begin
        if (sel_a_r) begin
          head_a_nxt = rdata;
        end else begin
          head_b_nxt = rdata;
        end
      end
      mse_pkg::OP_OUT_INIT: begin
        idx_nxt = '0;
      end
      mse_pkg::OP_OUT_RD: begin
      end
      mse_pkg::OP_OUT_LAT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rd_ext[15:0];
        out_last_nxt  = status.out_end;
        idx_nxt       = idx_r + CW'(1);
        if (status.out_end) begin
          cnt_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    width_r    <= width_nxt;
    base_r     <= base_nxt;
    a_r        <= a_nxt;
    a_end_r    <= a_end_nxt;
    b_r        <= b_nxt;
    b_end_r    <= b_end_nxt;
    k_r        <= k_nxt;
    idx_r      <= idx_nxt;
    head_a_r   <= head_a_nxt;
    head_b_r   <= head_b_nxt;
    src_r      <= src_nxt;
    sel_a_r    <= sel_a_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/merge_sort_engine.sv =====
// Top level of the merge sort engine: microcode sequencer plus datapath.
// Depends on mse_pkg, mse_seq, mse_datapath and mse_ram.
//
// Channel   Direction  Payload (low bit up)           Marker
// in_*      slave      tdata[15:0] = value_in         tlast = last_in
// out_*     master     tdata[15:0] = value_out        tlast = last_out
//
// Loading takes a new item every clock in the load step; an item flagged last
// starts the sort. Sorting runs ceil(log2 n) bottom-up passes; per run pair
// both heads are read, then each merge is followed by a fetch, all bound by
// the single read port. Output reads a result, then loads the output register.
// Reset clears the step counter, item count and output valid; no store sweep.
// The output register holds a result while out_tready is low; the block
// takes the next set as soon as the last result sits in that register.
`timescale 1ns / 1ps

module merge_sort_engine #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] value_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] value_out
  output logic        out_tlast
);

  mse_pkg::uword_t  ctrl;
  mse_pkg::status_t status;

  mse_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  mse_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (ctrl.op),
    .status     (status),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // The output register must be empty whenever a new result is loaded.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == mse_pkg::OP_OUT_LAT) |-> !out_tvalid)
    else $error("result loaded over a pending result");

  // Once a set ends, no further item is taken until its last result is loaded.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input taken while a set is being sorted");

  // After the final result is loaded the block is back in the load step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == mse_pkg::OP_OUT_LAT && status.out_end) |=> in_tready)
    else $error("block did not return to loading after the final result");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for merge_sort_engine: streams sets of values in,
// predicts each sorted set and checks every result. Depends on the RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 16;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } sorted_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [15:0] value_in
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [15:0] value_out
  logic        out_tlast;

  logic [15:0]  set_values[$];
  sorted_item_t sorted_q[$];

  int error_count   = 0;
  int sets_closed   = 0;
  int results_seen  = 0;
  int values_dropped = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;

  merge_sort_engine #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Sorts the collected set ascending and queues one expected result per value.
  task automatic close_set();
    int          i;
    int          j;
    logic [15:0] key;
    sorted_item_t item;
    for (i = 1; i < set_values.size(); i++) begin
      key = set_values[i];
      j = i;
      while (j > 0 && set_values[j-1] > key) begin
        set_values[j] = set_values[j-1];
        j--;
      end
      set_values[j] = key;
    end
    for (i = 0; i < set_values.size(); i++) begin
      item.value = set_values[i];
      item.last  = (i == set_values.size() - 1);
      sorted_q.push_back(item);
    end
    set_values.delete();
    sets_closed++;
  endtask

  // Checks results first, then records any request accepted at this edge.
  always @(posedge clk) begin
    sorted_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected result value %h last %b", $time, out_tdata, out_tlast);
        error_count++;
      end else begin
        want = sorted_q.pop_front();
        if (out_tdata !== want.value) begin
          $display("%0t: value mismatch, expected %h, actual %h",
                   $time, want.value, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want.last, out_tlast);
          error_count++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      if (set_values.size() < MAX_ITEMS) set_values.push_back(in_tdata);
      else values_dropped++;
      if (in_tlast) close_set();
    end
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_tready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_value(input logic [15:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (sorted_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_set(input logic [15:0] values[$]);
    int k;
    for (k = 0; k < values.size(); k++) send_value(values[k], k == values.size() - 1);
  endtask

  function automatic logic [15:0] pick_value(input int mode);
    case (mode)
      0:       return 16'($urandom());
      1:       return 16'($urandom_range(7));
      2:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'hFFF0 | 16'($urandom_range(15));
    endcase
  endfunction

  task automatic test_single_value();
    send_set('{16'h0000});
    send_set('{16'hFFFF});
    end_burst();
    wait_for_results();
  endtask

  task automatic test_extremes();
    send_set('{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF, 16'hAAAA, 16'h5555});
    send_set('{16'h0002, 16'h0001});
    end_burst();
    wait_for_results();
  endtask

  task automatic test_duplicates();
    send_set('{16'h0003, 16'h0003, 16'h0003, 16'h0001, 16'h0001});
    send_set('{16'hFFFF, 16'hFFFF});
    end_burst();
    wait_for_results();
  endtask

  // A full set, then a set one item past full whose last value is dropped but
  // which still ends the set.
  task automatic test_store_full();
    int k;
    for (k = 0; k < MAX_ITEMS; k++) send_value(16'(MAX_ITEMS - k), k == MAX_ITEMS - 1);
    for (k = 0; k <= MAX_ITEMS; k++) send_value(16'(k * 1021), k == MAX_ITEMS);
    end_burst();
    wait_for_results();
  endtask

  // The receiver holds off long enough that the block finishes sorting and
  // then stalls further requests while the sender keeps offering.
  task automatic test_backpressure();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 3000;
    for (k = 0; k < MAX_ITEMS; k++) send_value(pick_value(0), k == MAX_ITEMS - 1);
    for (k = 0; k < 20; k++) send_value(pick_value(1), k == 19);
    end_burst();
    wait_for_results();
  endtask

  task automatic test_random_sets(input int idle_send, input int recv_stall, input int target);
    int sent;
    int size;
    int k;
    int mode;
    int roll;
    send_idle_pct  = idle_send;
    recv_stall_pct = recv_stall;
    sent = 0;
    while (sent < target) begin
      roll = $urandom_range(99);
      if (roll < 80) size = $urandom_range(12, 1);
      else if (roll < 94) size = $urandom_range(MAX_ITEMS, 13);
      else size = $urandom_range(MAX_ITEMS + 6, MAX_ITEMS + 1);
      mode = $urandom_range(3);
      for (k = 0; k < size; k++) send_value(pick_value(mode), k == size - 1);
      sent += (size > MAX_ITEMS) ? MAX_ITEMS : size;
    end
    end_burst();
    wait_for_results();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct  = 31;
    recv_stall_pct = 84;
    test_single_value();
    test_extremes();
    test_duplicates();
    test_store_full();
    test_backpressure();
    test_random_sets(31, 84, 25);
    test_random_sets(84, 31, 25);
    test_random_sets(0, 0, 25);

    repeat (50) @(posedge clk);
    $display("Sorted %0d sets with %0d results checked; %0d values past a full store dropped.",
             sets_closed, results_seen, values_dropped);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
